/* rtl/dll_pkg.sv */
// ----------------------------------------------------------------------------
// dll_pkg
// shared types, codes and the microcode table of the linked list manager
// ----------------------------------------------------------------------------
package dll_pkg;

   localparam int unsigned NODE_W        = 8;
   localparam int unsigned COUNT_W       = 9;
   localparam int unsigned FUNC_W        = 2;
   localparam int unsigned NODE_COUNT_DEF = 256;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INS_BEFORE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_AFTER  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [NODE_W-1:0] ref_node;
      logic              ref_is_null;
      logic [NODE_W-1:0] new_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  head_node;
      logic               head_valid;
      logic [NODE_W-1:0]  tail_node;
      logic               tail_valid;
      logic [COUNT_W-1:0] node_count;
   } rsp_type;

   // link value: node index or null
   typedef struct packed {
      logic              is_null;
      logic [NODE_W-1:0] node;
   } link_type;

   localparam link_type LINK_NULL = '{is_null: 1'b1, node: '0};

   // operand selects of the datapath
   localparam int unsigned OPD_W = 3;
   localparam logic [OPD_W-1:0] OPD_NULL = 3'd0;
   localparam logic [OPD_W-1:0] OPD_NN   = 3'd1;
   localparam logic [OPD_W-1:0] OPD_CUR  = 3'd2;
   localparam logic [OPD_W-1:0] OPD_P    = 3'd3;
   localparam logic [OPD_W-1:0] OPD_N    = 3'd4;
   localparam logic [OPD_W-1:0] OPD_OLD  = 3'd5;

   // head / tail update codes
   localparam logic [1:0] PTR_NONE     = 2'd0;
   localparam logic [1:0] PTR_INS_HEAD = 2'd1;
   localparam logic [1:0] PTR_INS_TAIL = 2'd2;
   localparam logic [1:0] PTR_REMOVE   = 2'd3;

   // count update codes
   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_UP   = 2'd1;
   localparam logic [1:0] CNT_DOWN = 2'd2;

   // microprogram entry points
   localparam int unsigned UPC_W = 4;
   localparam logic [UPC_W-1:0] UPC_NOP     = 4'd0;
   localparam logic [UPC_W-1:0] UPC_IB_HEAD = 4'd1;
   localparam logic [UPC_W-1:0] UPC_IA_TAIL = 4'd3;
   localparam logic [UPC_W-1:0] UPC_IB_MID  = 4'd5;
   localparam logic [UPC_W-1:0] UPC_IA_MID  = 4'd8;
   localparam logic [UPC_W-1:0] UPC_RM      = 4'd11;

   typedef struct packed {
      logic             last;
      logic             rd_prev;
      logic             rd_next;
      logic [1:0]       cnt_op;
      logic [1:0]       ptr_op;
      logic             prev_we;
      logic [OPD_W-1:0] prev_addr;
      logic [OPD_W-1:0] prev_data;
      logic             next_we;
      logic [OPD_W-1:0] next_addr;
      logic [OPD_W-1:0] next_data;
   } uctrl_type;

   // microcode rom
   function automatic uctrl_type uop(input logic [UPC_W-1:0] pc);
      uctrl_type w;
      w = '0;
      unique case (pc)
         // nothing to do
         UPC_NOP: w.last = 1'b1;
         // insert at head
         UPC_IB_HEAD: begin
            w.prev_we = 1'b1; w.prev_addr = OPD_NN;  w.prev_data = OPD_NULL;
            w.next_we = 1'b1; w.next_addr = OPD_NN;  w.next_data = OPD_OLD;
            w.ptr_op  = PTR_INS_HEAD; w.cnt_op = CNT_UP;
         end
         UPC_IB_HEAD + 4'd1: begin
            w.prev_we = 1'b1; w.prev_addr = OPD_OLD; w.prev_data = OPD_NN;
            w.last    = 1'b1;
         end
         // insert at tail
         UPC_IA_TAIL: begin
            w.prev_we = 1'b1; w.prev_addr = OPD_NN;  w.prev_data = OPD_OLD;
            w.next_we = 1'b1; w.next_addr = OPD_NN;  w.next_data = OPD_NULL;
            w.ptr_op  = PTR_INS_TAIL; w.cnt_op = CNT_UP;
         end
         UPC_IA_TAIL + 4'd1: begin
            w.next_we = 1'b1; w.next_addr = OPD_OLD; w.next_data = OPD_NN;
            w.last    = 1'b1;
         end
         // insert before a middle node
         UPC_IB_MID: begin
            w.rd_prev = 1'b1; w.cnt_op = CNT_UP;
         end
         UPC_IB_MID + 4'd1: begin
            w.next_we = 1'b1; w.next_addr = OPD_P;   w.next_data = OPD_NN;
            w.prev_we = 1'b1; w.prev_addr = OPD_NN;  w.prev_data = OPD_P;
         end
         UPC_IB_MID + 4'd2: begin
            w.prev_we = 1'b1; w.prev_addr = OPD_CUR; w.prev_data = OPD_NN;
            w.next_we = 1'b1; w.next_addr = OPD_NN;  w.next_data = OPD_CUR;
            w.last    = 1'b1;
         end
         // insert after a middle node
         UPC_IA_MID: begin
            w.rd_next = 1'b1; w.cnt_op = CNT_UP;
         end
         UPC_IA_MID + 4'd1: begin
            w.prev_we = 1'b1; w.prev_addr = OPD_N;   w.prev_data = OPD_NN;
            w.next_we = 1'b1; w.next_addr = OPD_NN;  w.next_data = OPD_N;
         end
         UPC_IA_MID + 4'd2: begin
            w.next_we = 1'b1; w.next_addr = OPD_CUR; w.next_data = OPD_NN;
            w.prev_we = 1'b1; w.prev_addr = OPD_NN;  w.prev_data = OPD_CUR;
            w.last    = 1'b1;
         end
         // remove
         UPC_RM: begin
            w.rd_prev = 1'b1; w.rd_next = 1'b1; w.cnt_op = CNT_DOWN;
         end
         UPC_RM + 4'd1: begin
            w.ptr_op  = PTR_REMOVE;
            w.prev_we = 1'b1; w.prev_addr = OPD_N;   w.prev_data = OPD_P;
            w.next_we = 1'b1; w.next_addr = OPD_P;   w.next_data = OPD_N;
            w.last    = 1'b1;
         end
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

/* rtl/doubly_linked_list_manager.sv */
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// doubly linked list over a fixed table of node slots, one operation per item
// ----------------------------------------------------------------------------
// Each item is one operation: insert new_node before or after ref_node
// (a null reference inserts at the head or the tail) or remove ref_node.
// Every item gives one result with the head, tail and count after it.
// Per node previous and next links sit in two rams; head, tail and count
// are registers. Links are not cleared at reset: an operation must only
// follow links that earlier operations wrote. An item that names a node
// at or above NODE_COUNT, and the unused operation code, change nothing.
// Control is a microprogram: the accept cycle picks an entry point, then
// one control word per cycle drives the ram ports and the head, tail and
// count updates. An item occupies the block for the accept cycle plus its
// microprogram: 1 step for a no-op, 2 for insert at head or tail and for
// remove, 3 for insert in the middle. The length is set by the single
// read port of each link ram, whose registered data returns in the cycle
// after the address, and by the single write port that takes the up to
// two link writes per ram in separate cycles. The result sits in an
// output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
   parameter int unsigned NODE_COUNT = dll_pkg::NODE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dll_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dll_pkg::rsp_type rsp_payload
);

   import dll_pkg::*;

   localparam int unsigned AW = $clog2(NODE_COUNT);
   localparam int unsigned CW = $clog2(NODE_COUNT + 1);
   localparam int unsigned LW = $bits(link_type);

   // sequencer state
   logic             run_ff,  run_in;
   logic             hold_ff, hold_in;
   logic [UPC_W-1:0] pc_ff,   pc_in;

   // operands latched at accept
   logic [NODE_W-1:0] nn_ff,  nn_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   link_type          old_ff, old_in;

   // list state
   link_type      head_ff,  head_in;
   link_type      tail_ff,  tail_in;
   logic [CW-1:0] count_ff, count_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;

   uctrl_type        uc;
   logic             accept;
   logic             out_free;
   logic             ref_ok;
   logic             nn_ok;
   logic             at_head;
   logic             at_tail;
   logic [UPC_W-1:0] entry;

   // link ram ports
   link_type prev_rd, next_rd;
   link_type prev_wa, prev_wd, next_wa, next_wd;
   logic     prev_we, next_we;
   logic     prev_re, next_re;

   function automatic link_type operand(input logic [OPD_W-1:0] sel,
                                        input logic [NODE_W-1:0] nn,
                                        input logic [NODE_W-1:0] cur,
                                        input link_type p,
                                        input link_type n,
                                        input link_type old);
      link_type v;
      v = LINK_NULL;
      unique case (sel)
         OPD_NN:  v = '{is_null: 1'b0, node: nn};
         OPD_CUR: v = '{is_null: 1'b0, node: cur};
         OPD_P:   v = p;
         OPD_N:   v = n;
         OPD_OLD: v = old;
         default: v = LINK_NULL;
      endcase
      return v;
   endfunction

   assign uc       = uop(pc_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // busy while a microprogram runs or a finished result cannot move out
   assign req_stall = run_ff || (hold_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   // decode of the incoming item
   assign ref_ok  = req_payload.ref_is_null || (int'(req_payload.ref_node) < NODE_COUNT);
   assign nn_ok   = int'(req_payload.new_node) < NODE_COUNT;
   assign at_head = !head_ff.is_null && (head_ff.node == req_payload.ref_node);
   assign at_tail = !tail_ff.is_null && (tail_ff.node == req_payload.ref_node);

   always_comb begin
      entry = UPC_NOP;
      unique case (req_payload.func)
         FUNC_INS_BEFORE: begin
            if (ref_ok && nn_ok) begin
               entry = (req_payload.ref_is_null || at_head) ? UPC_IB_HEAD : UPC_IB_MID;
            end
         end
         FUNC_INS_AFTER: begin
            if (ref_ok && nn_ok) begin
               entry = (req_payload.ref_is_null || at_tail) ? UPC_IA_TAIL : UPC_IA_MID;
            end
         end
         FUNC_REMOVE: begin
            if (!req_payload.ref_is_null && ref_ok) begin
               entry = UPC_RM;
            end
         end
         default: entry = UPC_NOP;
      endcase
   end

   // link ram access, a write through a null link is dropped
   always_comb begin
      prev_wa = operand(uc.prev_addr, nn_ff, cur_ff, prev_rd, next_rd, old_ff);
      prev_wd = operand(uc.prev_data, nn_ff, cur_ff, prev_rd, next_rd, old_ff);
      next_wa = operand(uc.next_addr, nn_ff, cur_ff, prev_rd, next_rd, old_ff);
      next_wd = operand(uc.next_data, nn_ff, cur_ff, prev_rd, next_rd, old_ff);
      prev_we = run_ff && uc.prev_we && !prev_wa.is_null;
      next_we = run_ff && uc.next_we && !next_wa.is_null;
      prev_re = run_ff && uc.rd_prev;
      next_re = run_ff && uc.rd_next;
   end

   dll_ram #(
      .WIDTH (LW),
      .DEPTH (NODE_COUNT)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (AW'(prev_wa.node)),
      .wr_data (prev_wd),
      .rd_en   (prev_re),
      .rd_addr (AW'(cur_ff)),
      .rd_data (prev_rd)
   );

   dll_ram #(
      .WIDTH (LW),
      .DEPTH (NODE_COUNT)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (AW'(next_wa.node)),
      .wr_data (next_wd),
      .rd_en   (next_re),
      .rd_addr (AW'(cur_ff)),
      .rd_data (next_rd)
   );

   always_comb begin
      run_in       = run_ff;
      hold_in      = hold_ff;
      pc_in        = pc_ff;
      nn_in        = nn_ff;
      cur_in       = cur_ff;
      old_in       = old_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // result register drains, then takes a finished result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (hold_ff && out_free) begin
         rsp_valid_in      = 1'b1;
         rsp_in.head_node  = head_ff.is_null ? '0 : head_ff.node;
         rsp_in.head_valid = !head_ff.is_null;
         rsp_in.tail_node  = tail_ff.is_null ? '0 : tail_ff.node;
         rsp_in.tail_valid = !tail_ff.is_null;
         rsp_in.node_count = COUNT_W'(count_ff);
         hold_in           = 1'b0;
      end

      // latch operands and dispatch into the microprogram
      if (accept) begin
         run_in = 1'b1;
         pc_in  = entry;
         nn_in  = req_payload.new_node;
         cur_in = req_payload.ref_node;
         old_in = (req_payload.func == FUNC_INS_AFTER) ? tail_ff : head_ff;
      end

      if (run_ff) begin
         // step sequencing
         if (uc.last) begin
            run_in  = 1'b0;
            hold_in = 1'b1;
         end else begin
            pc_in = pc_ff + 1'b1;
         end

         // head and tail
         unique case (uc.ptr_op)
            PTR_INS_HEAD: begin
               head_in = '{is_null: 1'b0, node: nn_ff};
               if (old_ff.is_null) begin
                  tail_in = '{is_null: 1'b0, node: nn_ff};
               end
            end
            PTR_INS_TAIL: begin
               tail_in = '{is_null: 1'b0, node: nn_ff};
               if (old_ff.is_null) begin
                  head_in = '{is_null: 1'b0, node: nn_ff};
               end
            end
            PTR_REMOVE: begin
               // no predecessor: next becomes head, no successor: prev becomes tail
               if (prev_rd.is_null) begin
                  head_in = next_rd;
               end
               if (next_rd.is_null) begin
                  tail_in = prev_rd;
               end
            end
            default: ;
         endcase

         // saturating count
         unique case (uc.cnt_op)
            CNT_UP: begin
               if (count_ff < CW'(NODE_COUNT)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            CNT_DOWN: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         hold_ff      <= 1'b0;
         pc_ff        <= UPC_NOP;
         head_ff      <= LINK_NULL;
         tail_ff      <= LINK_NULL;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         hold_ff      <= hold_in;
         pc_ff        <= pc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nn_ff  <= nn_in;
      cur_ff <= cur_in;
      old_ff <= old_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/dll_ram.sv */
// ----------------------------------------------------------------------------
// dll_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dll_ram #(
   parameter int unsigned WIDTH = 9,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
